// File: rtl/hbdm_pkg.sv
`timescale 1ns / 1ps
// Package for the histogram bin decode and merge block: transaction types,
// Bayer order codes, luma weights and the compressed bin decode function.
// Depends on nothing; every other file of the block imports it.
package hbdm_pkg;

    localparam int BIN_W   = 16;
    localparam int COUNT_W = 28;
    localparam int WGT_W   = 16;
    localparam int PROD_W  = COUNT_W + WGT_W;

    localparam logic [WGT_W-1:0] W_RED   = 16'd19595;
    localparam logic [WGT_W-1:0] W_GREEN = 16'd38470;
    localparam logic [WGT_W-1:0] W_BLUE  = 16'd7471;

    typedef enum logic [1:0] {
        BAYER_RGGB = 2'd0,
        BAYER_GRBG = 2'd1,
        BAYER_GBRG = 2'd2,
        BAYER_BGGR = 2'd3
    } bayer_order_t;

    typedef struct packed {
        logic [BIN_W-1:0] plane0_bin;
        logic [BIN_W-1:0] plane1_bin;
        logic [BIN_W-1:0] plane2_bin;
        logic [BIN_W-1:0] plane3_bin;
    } bin_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] red_count;
        logic [COUNT_W-1:0] green_count;
        logic [COUNT_W-1:0] blue_count;
        logic [COUNT_W-1:0] luma_count;
    } count_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] red;
        logic [COUNT_W-1:0] green;
        logic [COUNT_W-1:0] blue;
    } rgb_t;

    // Zero exponent: mantissa times two. Otherwise hidden bit plus mantissa,
    // shifted left by the exponent.
    function automatic logic [COUNT_W-1:0] decode_bin(input logic [BIN_W-1:0] bin);
        logic [3:0]  expo;
        logic [11:0] mant;
        expo = bin[15:12];
        mant = bin[11:0];
        if (expo == 4'd0)
            return {{(COUNT_W-13){1'b0}}, mant, 1'b0};
        else
            return {{(COUNT_W-13){1'b0}}, 1'b1, mant} << expo;
    endfunction

endpackage

// File: rtl/hbdm_luma.sv
`timescale 1ns / 1ps
// Luma back end of the histogram bin decode and merge block: weight
// multiply stage, then sum, truncate and output register.
// Depends on hbdm_pkg.
module hbdm_luma (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rgb_valid,
    output logic                  rgb_ready,
    input  hbdm_pkg::rgb_t        rgb,
    output logic                  count_valid,
    input  logic                  count_ready,
    output hbdm_pkg::count_item_t count_item
);
    import hbdm_pkg::*;

    logic              s3_valid_reg;
    logic              s3_valid_next;
    logic              s3_ready;
    rgb_t              s3_rgb_reg;
    logic [PROD_W-1:0] s3_prod_r_reg;
    logic [PROD_W-1:0] s3_prod_g_reg;
    logic [PROD_W-1:0] s3_prod_b_reg;

    logic              s4_valid_reg;
    logic              s4_valid_next;
    logic              s4_ready;
    count_item_t       s4_item_reg;
    count_item_t       s4_item_next;
    logic [PROD_W+1:0] luma_sum;

    assign s4_ready  = !s4_valid_reg || count_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign rgb_ready = s3_ready;

    assign s3_valid_next = s3_ready ? rgb_valid : s3_valid_reg;
    assign s4_valid_next = s4_ready ? s3_valid_reg : s4_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    // Multiply stage: one product per channel.
    always_ff @(posedge clk)
    begin
        if (rgb_valid && s3_ready)
        begin
            s3_rgb_reg    <= rgb;
            s3_prod_r_reg <= PROD_W'(rgb.red)   * PROD_W'(W_RED);
            s3_prod_g_reg <= PROD_W'(rgb.green) * PROD_W'(W_GREEN);
            s3_prod_b_reg <= PROD_W'(rgb.blue)  * PROD_W'(W_BLUE);
        end
    end

    // Sum stage: weights add to one, so bits above the fraction fit in a count.
    always_comb
    begin
        luma_sum = (PROD_W+2)'(s3_prod_r_reg) + (PROD_W+2)'(s3_prod_g_reg)
                 + (PROD_W+2)'(s3_prod_b_reg);
        s4_item_next.red_count   = s3_rgb_reg.red;
        s4_item_next.green_count = s3_rgb_reg.green;
        s4_item_next.blue_count  = s3_rgb_reg.blue;
        s4_item_next.luma_count  = luma_sum[WGT_W +: COUNT_W];
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && s4_ready)
            s4_item_reg <= s4_item_next;
    end

    assign count_valid = s4_valid_reg;
    assign count_item  = s4_item_reg;

endmodule

// File: rtl/histogram_bin_decode_merge_top.sv
`timescale 1ns / 1ps
// Top level of the histogram bin decode and merge block: config register,
// decode/map stage, green average stage and the luma back end.
// Depends on hbdm_pkg and hbdm_luma.
//
// Usage:
// - bin channel (bin_valid/bin_ready/bin_item): one transaction carries the
//   four compressed bins of one bin index, planes 0..3 in memory order.
// - count channel (count_valid/count_ready/count_item): one transaction per
//   bin transaction, in order, with red, green, blue and luma counts.
// - cfg channel (cfg_valid/cfg_ready/cfg_data): writes the 2-bit Bayer order.
//   cfg_ready is always high; write only while no bin transaction is in flight.
// - Path: a bin accepted is loaded into stage 1, then moves through stage 2
//   and the weight multiply stage into the output register, which drives
//   count_item.
// - Throughput: one transaction per cycle while count_ready is high; four
//   pipeline stages (decode/map, green average, weight multiply, luma sum).
// - Reset: Bayer order returns to RGGB and every pipeline stage empties.
// - Stall: a stage holds its data while the stage below is full and blocked;
//   bubbles keep filling, so up to four transactions wait in the pipeline
//   before bin_ready drops. Nothing is dropped or repeated.
module histogram_bin_decode_merge_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_data,
    input  logic                  bin_valid,
    output logic                  bin_ready,
    input  hbdm_pkg::bin_item_t   bin_item,
    output logic                  count_valid,
    input  logic                  count_ready,
    output hbdm_pkg::count_item_t count_item
);
    import hbdm_pkg::*;

    // Configuration register.
    bayer_order_t       bayer_order_reg;
    bayer_order_t       bayer_order_next;

    // Stage 1: decoded and mapped channels.
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_ready;
    logic [COUNT_W-1:0] dec0;
    logic [COUNT_W-1:0] dec1;
    logic [COUNT_W-1:0] dec2;
    logic [COUNT_W-1:0] dec3;
    logic [COUNT_W-1:0] red_next;
    logic [COUNT_W-1:0] gr_next;
    logic [COUNT_W-1:0] gb_next;
    logic [COUNT_W-1:0] blue_next;
    logic [COUNT_W-1:0] s1_red_reg;
    logic [COUNT_W-1:0] s1_gr_reg;
    logic [COUNT_W-1:0] s1_gb_reg;
    logic [COUNT_W-1:0] s1_blue_reg;

    // Stage 2: averaged green.
    logic               s2_valid_reg;
    logic               s2_valid_next;
    logic               s2_ready;
    logic [COUNT_W:0]   green_sum;
    rgb_t               s2_rgb_reg;
    rgb_t               s2_rgb_next;
    logic               rgb_ready;

    // Config write; the channel never blocks.
    assign cfg_ready        = 1'b1;
    assign bayer_order_next = (cfg_valid && cfg_ready) ? bayer_order_t'(cfg_data)
                                                       : bayer_order_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bayer_order_reg <= BAYER_RGGB;
        else
            bayer_order_reg <= bayer_order_next;
    end

    // Ready ripples up from the luma back end: a stage takes new data when it
    // is empty or its contents advance in the same cycle.
    assign s2_ready  = !s2_valid_reg || rgb_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign bin_ready = s1_ready;

    assign s1_valid_next = s1_ready ? bin_valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Decode all four planes, then route them by the Bayer pattern.
    always_comb
    begin
        dec0 = decode_bin(bin_item.plane0_bin);
        dec1 = decode_bin(bin_item.plane1_bin);
        dec2 = decode_bin(bin_item.plane2_bin);
        dec3 = decode_bin(bin_item.plane3_bin);
        unique case (bayer_order_reg)
            BAYER_RGGB:
            begin
                red_next  = dec0;
                gr_next   = dec1;
                gb_next   = dec2;
                blue_next = dec3;
            end
            BAYER_GRBG:
            begin
                red_next  = dec1;
                gr_next   = dec0;
                gb_next   = dec3;
                blue_next = dec2;
            end
            BAYER_GBRG:
            begin
                red_next  = dec2;
                gr_next   = dec3;
                gb_next   = dec0;
                blue_next = dec1;
            end
            BAYER_BGGR:
            begin
                red_next  = dec3;
                gr_next   = dec2;
                gb_next   = dec1;
                blue_next = dec0;
            end
            default:
            begin
                red_next  = dec0;
                gr_next   = dec1;
                gb_next   = dec2;
                blue_next = dec3;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (bin_valid && s1_ready)
        begin
            s1_red_reg  <= red_next;
            s1_gr_reg   <= gr_next;
            s1_gb_reg   <= gb_next;
            s1_blue_reg <= blue_next;
        end
    end

    // Average the two greens, truncating the half.
    always_comb
    begin
        green_sum         = {1'b0, s1_gr_reg} + {1'b0, s1_gb_reg};
        s2_rgb_next.red   = s1_red_reg;
        s2_rgb_next.green = green_sum[COUNT_W:1];
        s2_rgb_next.blue  = s1_blue_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
            s2_rgb_reg <= s2_rgb_next;
    end

    // Weight multiply and luma sum, ending in the output register.
    hbdm_luma u_luma (
        .clk         (clk),
        .rst_n       (rst_n),
        .rgb_valid   (s2_valid_reg),
        .rgb_ready   (rgb_ready),
        .rgb         (s2_rgb_reg),
        .count_valid (count_valid),
        .count_ready (count_ready),
        .count_item  (count_item)
    );

    // An empty output register means every stage can take data.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !count_valid |-> bin_ready)
        else $error("bin_ready low with empty output register");

    // Luma is a weighted mean, so it never exceeds the largest channel.
    a_luma_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_valid |-> ((count_item.luma_count <= count_item.red_count)
                      || (count_item.luma_count <= count_item.green_count)
                      || (count_item.luma_count <= count_item.blue_count)))
        else $error("luma count above every channel count");

    // Green is the mean of the two greens, so it lies between them.
    a_green_between: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_ready && s1_valid_reg |=>
            ((s2_rgb_reg.green >= $past(s1_gr_reg)) || (s2_rgb_reg.green >= $past(s1_gb_reg))))
        else $error("green average below both greens");

endmodule
